/* design/mcmf_pkg.sv */
// Shared types, commands and constants for the min-cut / max-flow unit.
package mcmf_pkg;

	localparam int NODES_DEF    = 16;
	localparam int CAP_BITS_DEF = 16;
	localparam int NODE_W       = 4;
	localparam int CAP_W        = 16;
	localparam int OUT_MAX      = 16;

	localparam logic CFG_SOURCE = 1'b0;
	localparam logic CFG_SINK   = 1'b1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_SOLVE = 1'b1;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLR,
		CMD_LD_RD_UV,
		CMD_LD_RD_VU,
		CMD_LD_WR,
		CMD_BFS_INIT_FLOW,
		CMD_BFS_INIT_CUT,
		CMD_VIS_CLR,
		CMD_POP,
		CMD_SET_V,
		CMD_SCAN_RD,
		CMD_SCAN_EV,
		CMD_AUG_INIT,
		CMD_WALK_INIT,
		CMD_PRD_RD,
		CMD_RES_RD_FWD,
		CMD_NECK,
		CMD_SUB_FWD,
		CMD_ADD_BWD,
		CMD_EMIT
	} cmd_t;

	typedef enum logic [4:0] {
		ST_CLR_RST,
		ST_IDLE,
		ST_LD_VU,
		ST_LD_WR,
		ST_POP,
		ST_SETV,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_AUG_INIT,
		ST_A1_PRD,
		ST_A1_RES,
		ST_A1_MIN,
		ST_A2_PRD,
		ST_A2_RDF,
		ST_A2_WRF,
		ST_A2_WRB,
		ST_CLR_SOLVE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic ld_ok;
		logic solve_ok;
		logic src_ok;
		logic clr_last;
		logic q_nonempty;
		logic scan_end;
		logic hit_sink;
		logic walk_end;
		logic cut_mode;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

/* design/mcmf_ctrl.sv */
// Sequencing state machine for memory clearing, loads, path search, augmentation, cut marking and emission.
module mcmf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               kind,
	input  mcmf_pkg::status_t  status,
	output logic               in_ready,
	output mcmf_pkg::cmd_t     cmd
);

	mcmf_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcmf_pkg::ST_CLR_RST;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = mcmf_pkg::CMD_NONE;
		in_ready   = 1'b0;
		unique case (state_q)
			mcmf_pkg::ST_CLR_RST: begin
				cmd = mcmf_pkg::CMD_CLR;
				if (status.clr_last) state_next = mcmf_pkg::ST_IDLE;
			end
			mcmf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == mcmf_pkg::KIND_LOAD) begin
						if (status.ld_ok) begin
							cmd        = mcmf_pkg::CMD_LD_RD_UV;
							state_next = mcmf_pkg::ST_LD_VU;
						end
					end else if (status.solve_ok) begin
						cmd        = mcmf_pkg::CMD_BFS_INIT_FLOW;
						state_next = mcmf_pkg::ST_POP;
					end else if (status.src_ok) begin
						cmd        = mcmf_pkg::CMD_BFS_INIT_CUT;
						state_next = mcmf_pkg::ST_POP;
					end else begin
						cmd        = mcmf_pkg::CMD_VIS_CLR;
						state_next = mcmf_pkg::ST_CLR_SOLVE;
					end
				end
			end
			mcmf_pkg::ST_LD_VU: begin
				cmd        = mcmf_pkg::CMD_LD_RD_VU;
				state_next = mcmf_pkg::ST_LD_WR;
			end
			mcmf_pkg::ST_LD_WR: begin
				cmd        = mcmf_pkg::CMD_LD_WR;
				state_next = mcmf_pkg::ST_IDLE;
			end
			mcmf_pkg::ST_POP: begin
				if (status.q_nonempty) begin
					cmd        = mcmf_pkg::CMD_POP;
					state_next = mcmf_pkg::ST_SETV;
				end else if (status.cut_mode) begin
					state_next = mcmf_pkg::ST_CLR_SOLVE;
				end else begin
					cmd        = mcmf_pkg::CMD_BFS_INIT_CUT;
					state_next = mcmf_pkg::ST_POP;
				end
			end
			mcmf_pkg::ST_SETV: begin
				cmd        = mcmf_pkg::CMD_SET_V;
				state_next = mcmf_pkg::ST_SCAN_RD;
			end
			mcmf_pkg::ST_SCAN_RD: begin
				if (status.scan_end) begin
					state_next = mcmf_pkg::ST_POP;
				end else begin
					cmd        = mcmf_pkg::CMD_SCAN_RD;
					state_next = mcmf_pkg::ST_SCAN_EV;
				end
			end
			mcmf_pkg::ST_SCAN_EV: begin
				cmd = mcmf_pkg::CMD_SCAN_EV;
				if (status.hit_sink) state_next = mcmf_pkg::ST_AUG_INIT;
				else state_next = mcmf_pkg::ST_SCAN_RD;
			end
			mcmf_pkg::ST_AUG_INIT: begin
				cmd        = mcmf_pkg::CMD_AUG_INIT;
				state_next = mcmf_pkg::ST_A1_PRD;
			end
			mcmf_pkg::ST_A1_PRD: begin
				if (status.walk_end) begin
					cmd        = mcmf_pkg::CMD_WALK_INIT;
					state_next = mcmf_pkg::ST_A2_PRD;
				end else begin
					cmd        = mcmf_pkg::CMD_PRD_RD;
					state_next = mcmf_pkg::ST_A1_RES;
				end
			end
			mcmf_pkg::ST_A1_RES: begin
				cmd        = mcmf_pkg::CMD_RES_RD_FWD;
				state_next = mcmf_pkg::ST_A1_MIN;
			end
			mcmf_pkg::ST_A1_MIN: begin
				cmd        = mcmf_pkg::CMD_NECK;
				state_next = mcmf_pkg::ST_A1_PRD;
			end
			mcmf_pkg::ST_A2_PRD: begin
				if (status.walk_end) begin
					cmd        = mcmf_pkg::CMD_BFS_INIT_FLOW;
					state_next = mcmf_pkg::ST_POP;
				end else begin
					cmd        = mcmf_pkg::CMD_PRD_RD;
					state_next = mcmf_pkg::ST_A2_RDF;
				end
			end
			mcmf_pkg::ST_A2_RDF: begin
				cmd        = mcmf_pkg::CMD_RES_RD_FWD;
				state_next = mcmf_pkg::ST_A2_WRF;
			end
			mcmf_pkg::ST_A2_WRF: begin
				cmd        = mcmf_pkg::CMD_SUB_FWD;
				state_next = mcmf_pkg::ST_A2_WRB;
			end
			mcmf_pkg::ST_A2_WRB: begin
				cmd        = mcmf_pkg::CMD_ADD_BWD;
				state_next = mcmf_pkg::ST_A2_PRD;
			end
			mcmf_pkg::ST_CLR_SOLVE: begin
				cmd = mcmf_pkg::CMD_CLR;
				if (status.clr_last) state_next = mcmf_pkg::ST_EMIT;
			end
			mcmf_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd = mcmf_pkg::CMD_EMIT;
					if (status.emit_last) state_next = mcmf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = mcmf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* design/mcmf_dp.sv */
// Datapath: residual matrix memory, search queue, predecessor store, visited bits and output register.
module mcmf_dp #(
	parameter int NODES    = mcmf_pkg::NODES_DEF,
	parameter int CAP_BITS = mcmf_pkg::CAP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcmf_pkg::cmd_t                cmd,
	input  logic [mcmf_pkg::NODE_W-1:0]   source,
	input  logic [mcmf_pkg::NODE_W-1:0]   sink,
	input  logic [mcmf_pkg::NODE_W-1:0]   from_node,
	input  logic [mcmf_pkg::NODE_W-1:0]   to_node,
	input  logic [mcmf_pkg::CAP_W-1:0]    capacity,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [mcmf_pkg::NODE_W-1:0]   node_index,
	output logic                          in_cut,
	output logic                          last,
	output mcmf_pkg::status_t             status
);

	localparam int NW  = $clog2(NODES);
	localparam int AW  = $clog2(NODES * NODES);
	localparam int RB  = CAP_BITS + 6;
	localparam int WW  = RB + 1;
	localparam int CNT = (NODES < mcmf_pkg::OUT_MAX) ? NODES : mcmf_pkg::OUT_MAX;
	localparam logic [RB-1:0] RES_MAX = '1;

	logic [WW-1:0] mem [NODES*NODES];
	logic [NW-1:0] pred_mem [NODES];
	logic [NW-1:0] queue_mem [NODES];

	logic [WW-1:0] rd_q;
	logic [NW-1:0] pred_rd_q, q_rd_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [WW-1:0] mem_wd;
	logic          pred_we;
	logic [NW-1:0] pred_wa, pred_ra;
	logic          q_we;
	logic [NW-1:0] q_wa, q_ra, q_wd;

	logic [NODES-1:0]              visited_q;
	logic [NW:0]                   head_q, tail_q, d_q, steps_q;
	logic [NW-1:0]                 v_q, u_q, lu_q, lv_q;
	logic [RB-1:0]                 neck_q, uv_q;
	logic [CAP_BITS-1:0]           cap_q;
	logic [AW-1:0]                 clr_q;
	logic [mcmf_pkg::NODE_W-1:0]   k_q;
	logic                          cut_mode_q;
	logic                          out_valid_q, in_cut_q, last_q;
	logic [mcmf_pkg::NODE_W-1:0]   node_q;

	logic [NW-1:0] s_n, t_n, d_idx;
	logic [RB-1:0] rd_res, room, cap_ext, add_cap, ld_new;
	logic [RB:0]   used;
	logic          hit, hit_sink, tail_room;

	function automatic logic [AW-1:0] addr(input logic [NW-1:0] a, input logic [NW-1:0] b);
		addr = AW'(int'(a) * NODES + int'(b));
	endfunction

	assign s_n       = NW'(source);
	assign t_n       = NW'(sink);
	assign d_idx     = d_q[NW-1:0];
	assign rd_res    = rd_q[RB-1:0];
	assign hit       = (rd_res != '0) && !visited_q[d_idx] && (!cut_mode_q || rd_q[RB]);
	assign hit_sink  = !cut_mode_q && hit && (d_idx == t_n);
	assign tail_room = tail_q < (NW+1)'(NODES);

	assign used    = {1'b0, uv_q} + {1'b0, rd_res};
	assign room    = (used < {1'b0, RES_MAX}) ? RB'({1'b0, RES_MAX} - used) : '0;
	assign cap_ext = RB'(cap_q);
	assign add_cap = (cap_ext > room) ? room : cap_ext;
	assign ld_new  = uv_q + add_cap;

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = clr_q;
		mem_wd  = '0;
		mem_ra  = addr(v_q, d_idx);
		pred_we = 1'b0;
		pred_wa = d_idx;
		pred_ra = v_q;
		q_we    = 1'b0;
		q_wa    = '0;
		q_wd    = s_n;
		q_ra    = head_q[NW-1:0];
		unique case (cmd)
			mcmf_pkg::CMD_CLR: begin
				mem_we = 1'b1;
			end
			mcmf_pkg::CMD_LD_RD_UV: begin
				mem_ra = addr(NW'(from_node), NW'(to_node));
			end
			mcmf_pkg::CMD_LD_RD_VU: begin
				mem_ra = addr(lv_q, lu_q);
			end
			mcmf_pkg::CMD_LD_WR: begin
				mem_we = 1'b1;
				mem_wa = addr(lu_q, lv_q);
				mem_wd = {1'b1, ld_new};
			end
			mcmf_pkg::CMD_BFS_INIT_FLOW, mcmf_pkg::CMD_BFS_INIT_CUT: begin
				q_we = 1'b1;
			end
			mcmf_pkg::CMD_SCAN_EV: begin
				pred_we = hit && !cut_mode_q;
				q_we    = hit && !hit_sink && tail_room;
				q_wa    = tail_q[NW-1:0];
				q_wd    = d_idx;
			end
			mcmf_pkg::CMD_RES_RD_FWD: begin
				mem_ra = addr(pred_rd_q, v_q);
			end
			mcmf_pkg::CMD_SUB_FWD: begin
				mem_we = 1'b1;
				mem_wa = addr(u_q, v_q);
				mem_wd = {rd_q[RB], rd_res - neck_q};
				mem_ra = addr(v_q, u_q);
			end
			mcmf_pkg::CMD_ADD_BWD: begin
				mem_we = 1'b1;
				mem_wa = addr(v_q, u_q);
				mem_wd = {rd_q[RB], rd_res + neck_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (pred_we) pred_mem[pred_wa] <= v_q;
		pred_rd_q <= pred_mem[pred_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) queue_mem[q_wa] <= q_wd;
		q_rd_q <= queue_mem[q_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			d_q         <= '0;
			steps_q     <= '0;
			v_q         <= '0;
			u_q         <= '0;
			lu_q        <= '0;
			lv_q        <= '0;
			neck_q      <= '0;
			uv_q        <= '0;
			cap_q       <= '0;
			clr_q       <= '0;
			k_q         <= '0;
			cut_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
			node_q      <= '0;
			in_cut_q    <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= (cmd == mcmf_pkg::CMD_EMIT) || (out_valid_q && !out_ready);
			unique case (cmd)
				mcmf_pkg::CMD_CLR: begin
					clr_q <= status.clr_last ? '0 : clr_q + 1'b1;
				end
				mcmf_pkg::CMD_LD_RD_UV: begin
					lu_q  <= NW'(from_node);
					lv_q  <= NW'(to_node);
					cap_q <= CAP_BITS'(capacity);
				end
				mcmf_pkg::CMD_LD_RD_VU: begin
					uv_q <= rd_res;
				end
				mcmf_pkg::CMD_BFS_INIT_FLOW, mcmf_pkg::CMD_BFS_INIT_CUT: begin
					visited_q  <= NODES'(1) << s_n;
					head_q     <= '0;
					tail_q     <= (NW+1)'(1);
					cut_mode_q <= (cmd == mcmf_pkg::CMD_BFS_INIT_CUT);
				end
				mcmf_pkg::CMD_VIS_CLR: begin
					visited_q <= '0;
				end
				mcmf_pkg::CMD_POP: begin
					head_q <= head_q + 1'b1;
				end
				mcmf_pkg::CMD_SET_V: begin
					v_q <= q_rd_q;
					d_q <= '0;
				end
				mcmf_pkg::CMD_SCAN_EV: begin
					if (hit && !hit_sink) begin
						visited_q[d_idx] <= 1'b1;
						if (tail_room) tail_q <= tail_q + 1'b1;
					end
					d_q <= d_q + 1'b1;
				end
				mcmf_pkg::CMD_AUG_INIT: begin
					v_q     <= t_n;
					steps_q <= '0;
					neck_q  <= RES_MAX;
				end
				mcmf_pkg::CMD_WALK_INIT: begin
					v_q     <= t_n;
					steps_q <= '0;
				end
				mcmf_pkg::CMD_RES_RD_FWD: begin
					u_q <= pred_rd_q;
				end
				mcmf_pkg::CMD_NECK: begin
					if (rd_res < neck_q) neck_q <= rd_res;
					v_q     <= u_q;
					steps_q <= steps_q + 1'b1;
				end
				mcmf_pkg::CMD_ADD_BWD: begin
					v_q     <= u_q;
					steps_q <= steps_q + 1'b1;
				end
				mcmf_pkg::CMD_EMIT: begin
					node_q      <= k_q;
					in_cut_q    <= visited_q[NW'(k_q)];
					last_q      <= status.emit_last;
					k_q         <= status.emit_last ? '0 : k_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		status.ld_ok      = (int'(from_node) < NODES) && (int'(to_node) < NODES)
			&& (from_node != to_node);
		status.src_ok     = int'(source) < NODES;
		status.solve_ok   = status.src_ok && (int'(sink) < NODES) && (source != sink);
		status.clr_last   = clr_q == AW'(NODES * NODES - 1);
		status.q_nonempty = head_q < tail_q;
		status.scan_end   = d_q == (NW+1)'(NODES);
		status.hit_sink   = hit_sink;
		status.walk_end   = (v_q == s_n) || (steps_q == (NW+1)'(NODES));
		status.cut_mode   = cut_mode_q;
		status.out_free   = !out_valid_q || out_ready;
		status.emit_last  = k_q == mcmf_pkg::NODE_W'(CNT - 1);
	end

	assign out_valid  = out_valid_q;
	assign node_index = node_q;
	assign in_cut     = in_cut_q;
	assign last       = last_q;

endmodule

/* design/min_cut_max_flow_unit.sv */
// A load reads both directions of the pair and then writes it (an ignored load is only taken);
// a solve walks the residual matrix memory one entry at a time per breadth-first scan, then per
// path node reads predecessor and residual to find the bottleneck, then updates both residuals.
// After the search, a clearing pass empties the graph memory, and then one node result leaves
// per cycle while the output is taken.
// Throughput: one item at a time; one residual memory read per cycle sets the solve time.
// Reset: asynchronous active low; a clearing pass empties the graph memory before input is taken.
module min_cut_max_flow_unit #(
	parameter int NODES    = mcmf_pkg::NODES_DEF,
	parameter int CAP_BITS = mcmf_pkg::CAP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [mcmf_pkg::NODE_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [mcmf_pkg::NODE_W-1:0]  from_node,
	input  logic [mcmf_pkg::NODE_W-1:0]  to_node,
	input  logic [mcmf_pkg::CAP_W-1:0]   capacity,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mcmf_pkg::NODE_W-1:0]  node_index,
	output logic                         in_cut,
	output logic                         last
);

	logic [mcmf_pkg::NODE_W-1:0] source_q, sink_q;
	mcmf_pkg::cmd_t    cmd;
	mcmf_pkg::status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= mcmf_pkg::NODE_W'(0);
			sink_q   <= mcmf_pkg::NODE_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == mcmf_pkg::CFG_SOURCE) source_q <= cfg_data;
			if (cfg_index == mcmf_pkg::CFG_SINK) sink_q <= cfg_data;
		end
	end

	mcmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	mcmf_dp #(
		.NODES    (NODES),
		.CAP_BITS (CAP_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.source     (source_q),
		.sink       (sink_q),
		.from_node  (from_node),
		.to_node    (to_node),
		.capacity   (capacity),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.node_index (node_index),
		.in_cut     (in_cut),
		.last       (last),
		.status     (status)
	);

endmodule

/* design/mcmf_checker.sv */
// Port-level checks for the min-cut / max-flow unit and their binding.
module mcmf_checker #(
	parameter int NODES    = mcmf_pkg::NODES_DEF,
	parameter int CAP_BITS = mcmf_pkg::CAP_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic                         cfg_index,
	input logic [mcmf_pkg::NODE_W-1:0]  cfg_data,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         kind,
	input logic [mcmf_pkg::NODE_W-1:0]  from_node,
	input logic [mcmf_pkg::NODE_W-1:0]  to_node,
	input logic [mcmf_pkg::CAP_W-1:0]   capacity,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [mcmf_pkg::NODE_W-1:0]  node_index,
	input logic                         in_cut,
	input logic                         last
);

	localparam int CNT = (NODES < mcmf_pkg::OUT_MAX) ? NODES : mcmf_pkg::OUT_MAX;
	localparam int CW  = CAP_BITS;

	// A stalled result holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_index) && $stable(in_cut)
			&& $stable(last))
		else $error("result changed while stalled");

	// A solve transfer always leaves the unit busy in the next cycle.
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == mcmf_pkg::KIND_SOLVE) |=> !in_ready)
		else $error("input taken right after a solve");

	// Input stays blocked while a solve still has results to send.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |-> !in_ready)
		else $error("input taken in the middle of a result burst");

	// The final result of a solve describes the highest reported node.
	a_last_node: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> (node_index == mcmf_pkg::NODE_W'(CNT - 1)) && (CW > 0))
		else $error("last flag on the wrong node");

endmodule

bind min_cut_max_flow_unit mcmf_checker #(.NODES(NODES), .CAP_BITS(CAP_BITS)) u_mcmf_checker (.*);

/* test/mcmf_checker.sv */
// Checker for the min-cut / max-flow unit: predicts each cut and compares the node results.
`timescale 1ns / 1ps
module mcmf_scoreboard (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mcmf_pkg::NODE_W-1:0] cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        kind,
	input  logic [mcmf_pkg::NODE_W-1:0] from_node,
	input  logic [mcmf_pkg::NODE_W-1:0] to_node,
	input  logic [mcmf_pkg::CAP_W-1:0]  capacity,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [mcmf_pkg::NODE_W-1:0] node_index,
	input  logic                        in_cut,
	input  logic                        last,
	output int                          fail_count,
	output int                          cut_pending
);

	localparam int N = mcmf_pkg::NODES_DEF;
	localparam int CNT = (N < mcmf_pkg::OUT_MAX) ? N : mcmf_pkg::OUT_MAX;
	localparam logic [21:0] RES_LIMIT = 22'h3FFFFF;

	typedef struct packed {
		logic [mcmf_pkg::NODE_W-1:0] node;
		logic                        side;
		logic                        final_node;
	} member_t;

	member_t     cut_results[$];
	logic [21:0] residual[N*N];
	bit          loaded[N*N];
	bit          seen[N];
	logic [3:0]  came_from[N];
	logic [3:0]  frontier[N];
	logic [3:0]  src_node;
	logic [3:0]  snk_node;

	assign cut_pending = cut_results.size();

	// Breadth-first search; in cut mode only loaded pairs are followed.
	function automatic bit search_from(input logic [3:0] s, input logic [3:0] t,
			input bit cut_mode);
		int head;
		int tail;
		int v;
		head = 0;
		tail = 1;
		foreach (seen[i]) seen[i] = 0;
		seen[s] = 1;
		frontier[0] = s;
		while (head < tail) begin
			v = frontier[head];
			head++;
			for (int d = 0; d < N; d++) begin
				if (residual[v*N+d] != 0 && !seen[d] && (!cut_mode || loaded[v*N+d])) begin
					came_from[d] = 4'(v);
					if (!cut_mode && d == t) return 1;
					seen[d] = 1;
					if (tail < N) begin
						frontier[tail] = 4'(d);
						tail++;
					end
				end
			end
		end
		return 0;
	endfunction

	task automatic push_flow();
		logic [21:0] neck;
		int v;
		int u;
		int steps;
		neck = residual[came_from[snk_node]*N+snk_node];
		v = snk_node;
		for (steps = 0; v != src_node && steps < N; steps++) begin
			u = came_from[v];
			if (residual[u*N+v] < neck) neck = residual[u*N+v];
			v = u;
		end
		v = snk_node;
		for (steps = 0; v != src_node && steps < N; steps++) begin
			u = came_from[v];
			residual[u*N+v] -= neck;
			residual[v*N+u] += neck;
			v = u;
		end
	endtask

	task automatic solve_cut();
		member_t m;
		if (src_node != snk_node)
			while (search_from(src_node, snk_node, 0)) push_flow();
		void'(search_from(src_node, snk_node, 1));
		for (int k = 0; k < CNT; k++) begin
			m.node = mcmf_pkg::NODE_W'(k);
			m.side = seen[k];
			m.final_node = (k == CNT - 1);
			cut_results.push_back(m);
		end
		foreach (residual[i]) begin
			residual[i] = '0;
			loaded[i] = 0;
		end
	endtask

	task automatic load_edge(input logic [3:0] u, input logic [3:0] v,
			input logic [15:0] cap);
		logic [22:0] used;
		logic [22:0] room;
		logic [22:0] add;
		if (u == v) return;
		used = residual[u*N+v] + residual[v*N+u];
		room = (used < RES_LIMIT) ? RES_LIMIT - used : '0;
		add = (23'(cap) > room) ? room : 23'(cap);
		residual[u*N+v] += add[21:0];
		loaded[u*N+v] = 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		member_t want;
		if (!arst_n) begin
			src_node <= 4'd0;
			snk_node <= 4'd1;
			fail_count <= 0;
			cut_results.delete();
			foreach (residual[i]) begin
				residual[i] = '0;
				loaded[i] = 0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == mcmf_pkg::CFG_SOURCE) src_node <= cfg_data;
				if (cfg_index == mcmf_pkg::CFG_SINK) snk_node <= cfg_data;
			end
			if (in_valid && in_ready) begin
				if (kind == mcmf_pkg::KIND_LOAD) load_edge(from_node, to_node, capacity);
				else solve_cut();
			end
			if (out_valid && out_ready) begin
				if (cut_results.size() == 0) begin
					$display("%0t: unexpected transfer: node %0d in_cut %0b last %0b",
						$time, node_index, in_cut, last);
					fail_count <= fail_count + 1;
				end else begin
					want = cut_results.pop_front();
					if (want.node !== node_index || want.side !== in_cut
							|| want.final_node !== last) begin
						$display("%0t: expected node %0d in_cut %0b last %0b, got %0d %0b %0b",
							$time, want.node, want.side, want.final_node,
							node_index, in_cut, last);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* test/min_cut_max_flow_unit_tb.sv */
// Testbench top for the min-cut / max-flow unit: edge and solve stimulus, and the verdict.
`timescale 1ns / 1ps
module min_cut_max_flow_unit_tb;

	localparam int STALL_LIMIT = 600000;

	logic                        clk = 0;
	logic                        arst_n = 0;
	logic                        cfg_we = 0;
	logic                        cfg_index = mcmf_pkg::CFG_SOURCE;
	logic [mcmf_pkg::NODE_W-1:0] cfg_data = '0;
	logic                        in_valid = 0;
	logic                        in_ready;
	logic                        kind = mcmf_pkg::KIND_LOAD;
	logic [mcmf_pkg::NODE_W-1:0] from_node = '0;
	logic [mcmf_pkg::NODE_W-1:0] to_node = '0;
	logic [mcmf_pkg::CAP_W-1:0]  capacity = '0;
	logic                        out_valid;
	logic                        out_ready = 0;
	logic [mcmf_pkg::NODE_W-1:0] node_index;
	logic                        in_cut;
	logic                        last;
	int                          fail_count;
	int                          cut_pending;
	int                          items_sent = 0;
	int                          quiet_cycles = 0;
	bit                          calm = 0;
	logic [3:0]                  src_sel = 0;
	logic [3:0]                  snk_sel = 1;

	always #10 clk = ~clk;

	min_cut_max_flow_unit dut (.*);

	mcmf_scoreboard checker_i (.*);

	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(input logic k, input logic [3:0] f, input logic [3:0] t,
			input logic [15:0] c);
		if (!calm && $urandom_range(99) < 33) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		kind = k;
		from_node = f;
		to_node = t;
		capacity = c;
		while (!in_ready) @(negedge clk);
		@(negedge clk);
		in_valid = 0;
		if (k == mcmf_pkg::KIND_SOLVE || f != t) items_sent++;
	endtask

	task automatic settle();
		while (cut_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_ends(input logic [3:0] s, input logic [3:0] t);
		settle();
		src_sel = s;
		snk_sel = t;
		cfg_we = 1;
		cfg_index = mcmf_pkg::CFG_SOURCE;
		cfg_data = s;
		@(negedge clk);
		cfg_index = mcmf_pkg::CFG_SINK;
		cfg_data = t;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_edge();
		logic [3:0] f;
		logic [3:0] t;
		logic [15:0] c;
		f = ($urandom_range(3) == 0) ? src_sel : 4'($urandom_range(0, 15));
		t = ($urandom_range(3) == 0) ? snk_sel : 4'($urandom_range(0, 15));
		if ($urandom_range(9) == 0) t = f;
		c = ($urandom_range(1) == 0) ? 16'($urandom_range(1, 12)) : 16'($urandom);
		send(mcmf_pkg::KIND_LOAD, f, t, c);
	endtask

	initial begin
		int phase;
		int pick;
		repeat (4) @(negedge clk);
		arst_n = 1;
		while (!in_ready) @(negedge clk);

		// Directed: widest capacity, self loop, a bottleneck chain and its reverse.
		send(mcmf_pkg::KIND_LOAD, 4'd0, 4'd15, 16'hFFFF);
		send(mcmf_pkg::KIND_LOAD, 4'd15, 4'd1, 16'h0001);
		send(mcmf_pkg::KIND_LOAD, 4'd0, 4'd0, 16'hFFFF);
		send(mcmf_pkg::KIND_LOAD, 4'd0, 4'd2, 16'h0000);
		send(mcmf_pkg::KIND_LOAD, 4'd2, 4'd1, 16'h00FF);
		send(mcmf_pkg::KIND_LOAD, 4'd1, 4'd15, 16'h5555);
		send(mcmf_pkg::KIND_SOLVE, 4'd15, 4'd15, 16'hFFFF);
		send(mcmf_pkg::KIND_SOLVE, 4'd0, 4'd0, 16'h0000);
		set_ends(4'd15, 4'd0);
		send(mcmf_pkg::KIND_LOAD, 4'd15, 4'd7, 16'hAAAA);
		send(mcmf_pkg::KIND_LOAD, 4'd7, 4'd0, 16'h8000);
		send(mcmf_pkg::KIND_LOAD, 4'd7, 4'd3, 16'h0010);
		send(mcmf_pkg::KIND_SOLVE, 4'd0, 4'd0, 16'h0000);
		set_ends(4'd5, 4'd5);
		send(mcmf_pkg::KIND_LOAD, 4'd5, 4'd6, 16'h0003);
		send(mcmf_pkg::KIND_LOAD, 4'd6, 4'd9, 16'h0003);
		send(mcmf_pkg::KIND_SOLVE, 4'd3, 4'd9, 16'h1234);

		phase = 0;
		while (items_sent < 300) begin
			calm = (phase >= 10 && phase < 14);
			pick = $urandom_range(9);
			if (pick < 2) begin
				case ($urandom_range(3))
					0: set_ends(4'd0, 4'd15);
					1: set_ends(4'd15, 4'd0);
					2: set_ends(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
					default: set_ends(src_sel, src_sel);
				endcase
			end
			if (pick == 9) begin
				// Saturate one pair from both directions.
				repeat (70) send(mcmf_pkg::KIND_LOAD, src_sel, snk_sel, 16'hFFFF);
				repeat (5) send(mcmf_pkg::KIND_LOAD, snk_sel, src_sel, 16'($urandom));
			end else begin
				repeat ($urandom_range(2, 20)) random_edge();
			end
			send(mcmf_pkg::KIND_SOLVE, 4'($urandom), 4'($urandom), 16'($urandom));
			phase++;
		end

		settle();
		repeat (300) @(negedge clk);
		if (fail_count == 0 && cut_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

/* sim.f */
design/mcmf_pkg.sv
design/mcmf_ctrl.sv
design/mcmf_dp.sv
design/min_cut_max_flow_unit.sv
design/mcmf_checker.sv
test/mcmf_checker.sv
test/min_cut_max_flow_unit_tb.sv
